// ===== rtl/u8h_pkg.sv =====
`default_nettype none
package u8h_pkg;

	localparam int CP_BITS     = 32;
	localparam int BYTE_BITS   = 8;
	localparam int MAX_BYTES   = 4;
	localparam int REPORT_BITS = 32;
	localparam int HASH_ROT    = 7;

	localparam logic [CP_BITS-1:0] SURR_LOW  = 32'h0000_D800;
	localparam logic [CP_BITS-1:0] SURR_END  = 32'h0000_E000;
	localparam logic [CP_BITS-1:0] POINT_MAX = 32'h0010_FFFF;
	localparam logic [CP_BITS-1:0] ONE_BYTE_END   = 32'h0000_0080;
	localparam logic [CP_BITS-1:0] TWO_BYTE_END   = 32'h0000_0800;
	localparam logic [CP_BITS-1:0] THREE_BYTE_END = 32'h0001_0000;

	typedef logic [REPORT_BITS-1:0] report_t;

	// one classified code point: its bytes, index of the final byte, error mark
	typedef struct packed {
		logic [MAX_BYTES-1:0][BYTE_BITS-1:0] bytes;
		logic [1:0]                          last_idx;
		logic                                bad;
	} enc_t;

	localparam int ENC_BITS = $bits(enc_t);

	function automatic logic is_bad(input logic [CP_BITS-1:0] cp);
		return ((cp >= SURR_LOW) && (cp < SURR_END)) || (cp > POINT_MAX);
	endfunction

	function automatic enc_t encode(input logic [CP_BITS-1:0] cp);
		enc_t e;
		e = '0;
		priority if (is_bad(cp)) begin
			e.bad = 1'b1;
		end else if (cp < ONE_BYTE_END) begin
			e.bytes[0] = cp[7:0];
			e.last_idx = 2'd0;
		end else if (cp < TWO_BYTE_END) begin
			e.bytes[0] = {3'b110, cp[10:6]};
			e.bytes[1] = {2'b10, cp[5:0]};
			e.last_idx = 2'd1;
		end else if (cp < THREE_BYTE_END) begin
			e.bytes[0] = {4'b1110, cp[15:12]};
			e.bytes[1] = {2'b10, cp[11:6]};
			e.bytes[2] = {2'b10, cp[5:0]};
			e.last_idx = 2'd2;
		end else begin
			e.bytes[0] = {5'b11110, cp[20:18]};
			e.bytes[1] = {2'b10, cp[17:12]};
			e.bytes[2] = {2'b10, cp[11:6]};
			e.bytes[3] = {2'b10, cp[5:0]};
			e.last_idx = 2'd3;
		end
		return e;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/u8h_front.sv =====
`default_nettype none
module u8h_front #(
	parameter int HASH_BITS  = 64,
	parameter int COUNT_BITS = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [u8h_pkg::CP_BITS-1:0] code_point,
	input  wire logic                       starts_string,
	output logic                            q_valid,
	input  wire logic                       q_ready,
	output u8h_pkg::enc_t                   enc,
	output logic [HASH_BITS-1:0]            hash_value,
	output u8h_pkg::report_t                utf8_bytes,
	output u8h_pkg::report_t                utf16_words,
	output u8h_pkg::report_t                points_seen
);
	import u8h_pkg::*;

	logic [HASH_BITS-1:0]  hash_q;
	logic [COUNT_BITS-1:0] byte_total_q;
	logic [COUNT_BITS-1:0] word_total_q;
	logic [COUNT_BITS-1:0] point_total_q;

	logic [HASH_BITS-1:0]  hash_base;
	logic [HASH_BITS-1:0]  hash_next;
	logic [COUNT_BITS-1:0] byte_base, word_base, point_base;
	logic [COUNT_BITS-1:0] byte_next, word_next, point_next;
	logic [2:0]            byte_inc;
	logic [2:0]            word_inc;
	logic                  accept;

	function automatic logic [COUNT_BITS-1:0] sat_add(
		input logic [COUNT_BITS-1:0] cnt,
		input logic [2:0]            inc
	);
		logic [COUNT_BITS:0] sum;
		sum = {1'b0, cnt} + (COUNT_BITS+1)'(inc);
		return sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
	endfunction

	assign in_ready = q_ready;
	assign q_valid  = in_valid;
	assign accept   = in_valid && q_ready;

	always_comb begin
		enc        = encode(code_point);
		hash_base  = starts_string ? '0 : hash_q;
		byte_base  = starts_string ? '0 : byte_total_q;
		word_base  = starts_string ? '0 : word_total_q;
		point_base = starts_string ? '0 : point_total_q;
		byte_inc   = {1'b0, enc.last_idx} + 3'd1;
		word_inc   = (code_point < THREE_BYTE_END) ? 3'd1 : 3'd2;
		hash_next  = {hash_base[HASH_BITS-1-HASH_ROT:0], hash_base[HASH_BITS-1 -: HASH_ROT]}
			^ HASH_BITS'(code_point);
		byte_next  = sat_add(byte_base, byte_inc);
		word_next  = sat_add(word_base, word_inc);
		point_next = sat_add(point_base, 3'd1);
		// an invalid code point reports the state as it stands, after any clear
		if (enc.bad) begin
			hash_next  = hash_base;
			byte_next  = byte_base;
			word_next  = word_base;
			point_next = point_base;
		end
	end

	assign hash_value  = hash_next;
	assign utf8_bytes  = REPORT_BITS'(byte_next);
	assign utf16_words = REPORT_BITS'(word_next);
	assign points_seen = REPORT_BITS'(point_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q        <= '0;
			byte_total_q  <= '0;
			word_total_q  <= '0;
			point_total_q <= '0;
		end else if (accept) begin
			hash_q        <= hash_next;
			byte_total_q  <= byte_next;
			word_total_q  <= word_next;
			point_total_q <= point_next;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/u8h_queue.sv =====
`default_nettype none
module u8h_queue #(
	parameter int DATA_BITS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push_valid,
	output logic                      push_ready,
	input  wire logic [DATA_BITS-1:0] push_data,
	output logic                      pop_valid,
	input  wire logic                 pop_ready,
	output logic [DATA_BITS-1:0]      pop_data
);

	logic [DATA_BITS-1:0] mem_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;
	logic                 push;
	logic                 pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/u8h_back.sv =====
`default_nettype none
module u8h_back #(
	parameter int HASH_BITS = 64,
	parameter int ENT_BITS  = u8h_pkg::ENC_BITS + HASH_BITS + 3 * u8h_pkg::REPORT_BITS,
	parameter int OUT_BITS  = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	output logic                     q_ready,
	input  wire logic [ENT_BITS-1:0] q_data,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [OUT_BITS-1:0]      m_tdata,
	output logic                     m_tlast,
	output logic                     m_tuser
);
	import u8h_pkg::*;

	logic [ENT_BITS-1:0]  ent_q;
	logic [1:0]           idx_q;
	logic                 busy_q;
	enc_t                 enc;
	logic [HASH_BITS-1:0] hash;
	report_t              bytes_rep, words_rep, points_rep;
	logic                 last;
	logic                 load;

	assign {enc, hash, bytes_rep, words_rep, points_rep} = ent_q;

	assign last     = (idx_q == enc.last_idx);
	assign load     = !busy_q || (m_tready && last);
	assign q_ready  = load;
	assign m_tvalid = busy_q;
	assign m_tlast  = last;
	assign m_tuser  = enc.bad;
	assign m_tdata  = OUT_BITS'({points_rep, words_rep, bytes_rep, hash, enc.bytes[idx_q]});

	always_ff @(posedge clk) begin
		if (load && q_valid) begin
			ent_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (load) begin
			busy_q <= q_valid;
			idx_q  <= 2'd0;
		end else if (m_tready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/utf32_to_utf8_with_hash_core.sv =====
`default_nettype none
// UTF-32 to UTF-8 encoder with a running rotate-xor string hash and saturating
// UTF-8 byte, UTF-16 word and code point counts. A code point with s_tuser set
// starts a new string. Each valid code point gives 1 to 4 output transactions,
// one UTF-8 byte per cycle while m_tready holds, with m_tlast on the final byte;
// a surrogate or a value above 10FFFF gives one transaction with m_tuser set and
// a zero byte, and leaves the hash and counts alone but for a clear by s_tuser.
// Every output carries the hash and counts after its code point. The front stage
// classifies and updates state in the cycle of acceptance, a two-entry queue
// follows, and the back stage emits bytes, taking the next code point from the
// queue as the final byte of the one before is accepted.
module utf32_to_utf8_with_hash_core #(
	parameter int HASH_BITS  = 64,
	parameter int COUNT_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// code_point
	input  wire logic [31:0] s_tdata,
	// starts_string
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// out_byte, hash_value, utf8_bytes, utf16_words, points_seen, zero pad
	output logic [((8 + HASH_BITS + 96 + 7) / 8) * 8 - 1:0] m_tdata,
	// last_of_run
	output logic             m_tlast,
	// bad_code_point
	output logic             m_tuser
);
	import u8h_pkg::*;

	localparam int ENT_BITS = ENC_BITS + HASH_BITS + 3 * REPORT_BITS;
	localparam int OUT_BITS = ((BYTE_BITS + HASH_BITS + 3 * REPORT_BITS + 7) / 8) * 8;

	enc_t                 enc;
	logic [HASH_BITS-1:0] hash;
	report_t              bytes_rep, words_rep, points_rep;
	logic                 fq_valid, fq_ready;
	logic                 bq_valid, bq_ready;
	logic [ENT_BITS-1:0]  bq_data;

	u8h_front #(
		.HASH_BITS  (HASH_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.code_point    (s_tdata),
		.starts_string (s_tuser),
		.q_valid       (fq_valid),
		.q_ready       (fq_ready),
		.enc           (enc),
		.hash_value    (hash),
		.utf8_bytes    (bytes_rep),
		.utf16_words   (words_rep),
		.points_seen   (points_rep)
	);

	u8h_queue #(
		.DATA_BITS (ENT_BITS)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  ({enc, hash, bytes_rep, words_rep, points_rep}),
		.pop_valid  (bq_valid),
		.pop_ready  (bq_ready),
		.pop_data   (bq_data)
	);

	u8h_back #(
		.HASH_BITS (HASH_BITS),
		.ENT_BITS  (ENT_BITS),
		.OUT_BITS  (OUT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (bq_valid),
		.q_ready  (bq_ready),
		.q_data   (bq_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire
